// ----- hdl/bps_pkg.sv -----
// ----------------------------------------------------------------------------
// Batch process sequencer package
// Shared types, step codes, drive bit positions and the step transition
// helpers used by the scan logic and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package bps_pkg;

	// Step codes as they appear on the step_code output.
	localparam logic [2:0] STEP_STANDBY  = 3'd0;
	localparam logic [2:0] STEP_PUMP     = 3'd1;
	localparam logic [2:0] STEP_CLEAN    = 3'd2;
	localparam logic [2:0] STEP_POWER    = 3'd3;
	localparam logic [2:0] STEP_XFER     = 3'd4;
	localparam logic [2:0] STEP_INTERVAL = 3'd5;
	localparam logic [2:0] STEP_FAULT    = 3'd6;

	// Drive bit positions and masks.
	localparam int D_PUMP  = 0;
	localparam int D_POWER = 1;
	localparam int D_CLEAN = 2;
	localparam int D_XFER  = 3;
	localparam int D_BEEP  = 4;
	localparam logic [4:0] D_FOUR_MASK = 5'b01111;

	// Error substates.
	localparam logic [1:0] ERR_SUB_TEMP_LOW  = 2'd0;
	localparam logic [1:0] ERR_SUB_TEMP_HIGH = 2'd1;
	localparam logic [1:0] ERR_SUB_PFAULT    = 2'd2;

	// Timing and temperature constants.
	localparam logic [15:0]       SECS_PER_MIN = 16'd60;
	localparam logic [15:0]       ITV_SECS     = 16'd5;
	localparam logic signed [12:0] TEMP_MIN    = 13'sd10;
	localparam logic [11:0]       TENTHS       = 12'd10;

	// Configuration register indexes.
	localparam logic CFG_TEMP_LIMIT  = 1'b0;
	localparam logic CFG_RUN_MINUTES = 1'b1;

	localparam logic [7:0] TEMP_LIMIT_RST  = 8'd80;
	localparam logic [9:0] RUN_MINUTES_RST = 10'd30;

	// One scan of sensor and button inputs.
	typedef struct packed {
		logic              clean_valve_closed;
		logic              transfer_valve_closed;
		logic              level_high;
		logic              level_mid;
		logic              level_low;
		logic              power_fault;
		logic              receiver_full;
		logic signed [11:0] temperature;
		logic              second_tick;
		logic              start_stop;
		logic              return_pressed;
		logic              return_released;
	} bps_in_t;

	// Sequencer state.
	typedef struct packed {
		logic [2:0]  step;
		logic [1:0]  sub;
		logic [15:0] cnt;
		logic [2:0]  sv_step;
		logic [1:0]  sv_sub;
		logic [4:0]  drv;
	} bps_state_t;

	// One result as held in the output register.
	typedef struct packed {
		logic [2:0]  step;
		logic [1:0]  sub;
		logic [4:0]  drv;
		logic [15:0] cnt;
		logic        exit_req;
	} bps_res_t;

	// Action of the current step and substate on the drives and countdown.
	function automatic bps_state_t sub_action(bps_state_t s, logic [9:0] run_min);
		bps_state_t r;
		logic [15:0] load;
		r = s;
		load = 16'({6'd0, run_min} * SECS_PER_MIN);
		case (r.step)
			STEP_STANDBY: begin
				if (r.sub == 2'd0) r.drv = r.drv & ~D_FOUR_MASK;
			end
			STEP_PUMP: begin
				if (r.sub == 2'd1) r.drv[D_PUMP] = 1'b1;
			end
			STEP_CLEAN: begin
				if (r.sub == 2'd1) r.drv[D_CLEAN] = 1'b1;
				else if (r.sub == 2'd2) r.drv[D_CLEAN] = 1'b0;
			end
			STEP_POWER: begin
				if (r.sub == 2'd0) begin
					r.drv[D_CLEAN] = 1'b0;
					r.drv[D_XFER]  = 1'b0;
					r.drv[D_PUMP]  = 1'b0;
				end else if (r.sub == 2'd1) begin
					r.drv[D_POWER] = 1'b1;
					if (r.cnt == 16'd0) r.cnt = load;
				end
			end
			STEP_XFER: begin
				if (r.sub == 2'd1) r.drv[D_XFER] = 1'b1;
				else if (r.sub == 2'd0 || r.sub == 2'd2) r.drv[D_XFER] = 1'b0;
			end
			STEP_FAULT: begin
				r.drv = r.drv & ~D_FOUR_MASK;
				if (r.sub == ERR_SUB_PFAULT) r.drv[D_BEEP] = 1'b1;
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	// Enter a step, running its entry action.
	function automatic bps_state_t enter_step(bps_state_t s, logic [2:0] to,
			logic [9:0] run_min);
		bps_state_t r;
		logic [2:0] tgt;
		r = s;
		tgt = to;
		if (tgt > STEP_FAULT) begin
			tgt = STEP_STANDBY;
			r.sub = 2'd0;
		end
		r.step = tgt;
		if (tgt == STEP_POWER) r.sub = 2'd0;
		if (tgt == STEP_INTERVAL) begin
			r.drv = r.drv & ~D_FOUR_MASK;
			r.cnt = ITV_SECS;
		end else begin
			r = sub_action(r, run_min);
		end
		return r;
	endfunction

	// Move to another substate of the current step.
	function automatic bps_state_t go_sub(bps_state_t s, logic [1:0] sub,
			logic [9:0] run_min);
		bps_state_t r;
		r = s;
		r.sub = sub;
		return sub_action(r, run_min);
	endfunction

	// Save the current position and enter the error step.
	function automatic bps_state_t go_error(bps_state_t s, logic [1:0] sub,
			logic [9:0] run_min);
		bps_state_t r;
		r = s;
		r.sv_step = r.step;
		r.sv_sub  = r.sub;
		r.sub     = sub;
		return enter_step(r, STEP_FAULT, run_min);
	endfunction

	// Return to the saved position.
	function automatic bps_state_t resume(bps_state_t s, logic [9:0] run_min);
		bps_state_t r;
		r = s;
		r.sub = r.sv_sub;
		return enter_step(r, r.sv_step, run_min);
	endfunction

endpackage

`default_nettype wire

// ----- hdl/bps_next.sv -----
// ----------------------------------------------------------------------------
// Batch process sequencer scan logic
// Computes the next sequencer state and the exit flag for one scan.
// ----------------------------------------------------------------------------
`default_nettype none

module bps_next (
	input  bps_pkg::bps_state_t cur,
	input  bps_pkg::bps_in_t    scan,
	input  logic [7:0]          temp_limit_deg,
	input  logic [9:0]          run_minutes,
	output bps_pkg::bps_state_t nxt,
	output logic                exit_request
);
	import bps_pkg::*;

	logic [11:0]        lim10;
	logic signed [12:0] temp13;
	logic signed [12:0] lim13;
	logic               t_low;
	logic               t_high;
	logic               trip;
	logic [1:0]         trip_sub;
	logic               t_above_min;
	logic               t_below_lim;
	bps_state_t         n;

	// Temperature comparisons against the fixed minimum and the set limit.
	assign lim10       = 12'({4'd0, temp_limit_deg} * TENTHS);
	assign temp13      = {scan.temperature[11], scan.temperature};
	assign lim13       = $signed({1'b0, lim10});
	assign t_low       = temp13 < TEMP_MIN;
	assign t_high      = temp13 > lim13;
	assign trip        = t_low || t_high;
	assign trip_sub    = t_low ? ERR_SUB_TEMP_LOW : ERR_SUB_TEMP_HIGH;
	assign t_above_min = temp13 > TEMP_MIN;
	assign t_below_lim = temp13 < lim13;

	// Checks in priority order, then the substate logic of the current step.
	always_comb begin
		n = cur;
		exit_request = 1'b0;
		if (scan.return_released) begin
			exit_request = 1'b1;
		end else begin
			if (scan.return_pressed) n.drv = n.drv & ~D_FOUR_MASK;
			if (n.step > STEP_FAULT) begin
				n.sub = 2'd0;
				n = enter_step(n, STEP_STANDBY, run_minutes);
			end
			if (n.step != STEP_STANDBY && scan.start_stop) begin
				n.sub = 2'd0;
				n = enter_step(n, STEP_STANDBY, run_minutes);
			end else begin
				case (n.step)
					STEP_STANDBY: begin
						if (trip) begin
							n = go_error(n, trip_sub, run_minutes);
						end else if (n.sub == 2'd0) begin
							if (scan.clean_valve_closed && scan.transfer_valve_closed)
								n = go_sub(n, 2'd1, run_minutes);
						end else if (n.sub == 2'd1) begin
							if (scan.start_stop) begin
								n.sub = 2'd0;
								n = enter_step(n, STEP_PUMP, run_minutes);
							end
						end
					end
					STEP_PUMP: begin
						if (trip) begin
							n = go_error(n, trip_sub, run_minutes);
						end else if (n.sub == 2'd0) begin
							if (scan.level_low) n = go_sub(n, 2'd1, run_minutes);
						end else if (n.sub == 2'd1) begin
							if (scan.level_mid) begin
								n.sub = 2'd0;
								n.drv[D_PUMP] = 1'b0;
								n = enter_step(n, STEP_CLEAN, run_minutes);
							end
						end
					end
					STEP_CLEAN: begin
						if (trip) begin
							n = go_error(n, trip_sub, run_minutes);
						end else if (n.sub == 2'd0) begin
							if (scan.level_mid) n = go_sub(n, 2'd1, run_minutes);
						end else if (n.sub == 2'd1) begin
							if (scan.level_high) n = go_sub(n, 2'd2, run_minutes);
						end else if (n.sub == 2'd2) begin
							if (scan.clean_valve_closed) begin
								n.sub = 2'd0;
								n = enter_step(n, STEP_POWER, run_minutes);
							end
						end
					end
					STEP_POWER: begin
						if (trip) begin
							n = go_error(n, trip_sub, run_minutes);
						end else if (scan.power_fault) begin
							n = go_error(n, ERR_SUB_PFAULT, run_minutes);
						end else if (n.sub == 2'd0) begin
							if (scan.level_high && scan.clean_valve_closed
									&& scan.transfer_valve_closed)
								n = go_sub(n, 2'd1, run_minutes);
						end else if (n.sub == 2'd1) begin
							if (scan.second_tick) begin
								if (n.cnt != 16'd0) n.cnt = n.cnt - 16'd1;
								if (n.cnt == 16'd0) begin
									n.sub = 2'd0;
									n.drv[D_POWER] = 1'b0;
									n = enter_step(n, STEP_XFER, run_minutes);
								end
							end
						end
					end
					STEP_XFER: begin
						if (n.sub == 2'd0) begin
							if (!scan.receiver_full) begin
								n.drv[D_BEEP] = 1'b0;
								n = go_sub(n, 2'd1, run_minutes);
							end
						end else if (n.sub == 2'd1) begin
							if (scan.level_low) n = go_sub(n, 2'd2, run_minutes);
						end else if (n.sub == 2'd2) begin
							if (scan.transfer_valve_closed) begin
								n.sub = 2'd0;
								n = enter_step(n, STEP_INTERVAL, run_minutes);
							end
						end
					end
					STEP_INTERVAL: begin
						if (trip) begin
							n = go_error(n, trip_sub, run_minutes);
						end else if (scan.second_tick) begin
							if (n.cnt != 16'd0) n.cnt = n.cnt - 16'd1;
							if (n.cnt == 16'd0) n = enter_step(n, STEP_PUMP, run_minutes);
						end
					end
					STEP_FAULT: begin
						if (n.sub == ERR_SUB_TEMP_LOW) begin
							if (t_above_min) n = resume(n, run_minutes);
						end else if (n.sub == ERR_SUB_TEMP_HIGH) begin
							if (t_below_lim) n = resume(n, run_minutes);
						end else if (n.sub == ERR_SUB_PFAULT) begin
							if (!scan.power_fault) begin
								n.drv[D_BEEP] = 1'b0;
								n = resume(n, run_minutes);
							end else if (scan.second_tick) begin
								n.drv[D_BEEP] = ~n.drv[D_BEEP];
							end
						end
					end
					default: begin
					end
				endcase
			end
		end
		nxt = n;
	end

endmodule

`default_nettype wire

// ----- hdl/batch_process_sequencer.sv -----
// ----------------------------------------------------------------------------
// Batch process sequencer
// Step sequencer of a batch process: one scan in, one drive result out.
// ----------------------------------------------------------------------------
// Usage:
// Each request on the input channel (in_valid/in_ready) is one scan of the
// limit switches, level sensors, fault bits, temperature, tick and buttons.
// Each scan yields exactly one result on the output channel
// (out_valid/out_ready): step, substate, drives, countdown and exit flag.
// A scan is captured in an input register; on the next edge at which the
// output register is free it is evaluated against the sequencer state and
// the result is loaded into the output register. One scan per cycle is
// taken while out_ready stays high. The rate is set by the single
// evaluation stage between the two registers.
// When the receiver stalls, the result is held, the pending scan waits in
// the input register and in_ready drops once both are full.
// Reset clears the sequencer to standby with all drives off and loads the
// default limits (80 degrees, 30 minutes). Configuration writes on
// cfg_we/cfg_index/cfg_data take effect at once and are meant for idle time.
// ----------------------------------------------------------------------------
`default_nettype none

module batch_process_sequencer (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration write port
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [9:0]  cfg_data,
	// Input channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        clean_valve_closed,
	input  logic        transfer_valve_closed,
	input  logic        level_high,
	input  logic        level_mid,
	input  logic        level_low,
	input  logic        power_fault,
	input  logic        receiver_full,
	input  logic signed [11:0] temperature,
	input  logic        second_tick,
	input  logic        start_stop,
	input  logic        return_pressed,
	input  logic        return_released,
	// Output channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  step_code,
	output logic [1:0]  substate,
	output logic        pump_on,
	output logic        power_on,
	output logic        clean_valve_open,
	output logic        transfer_valve_open,
	output logic        beeper_on,
	output logic [15:0] seconds_left,
	output logic        exit_request
);
	import bps_pkg::*;

	logic [7:0] temp_limit_deg_q;
	logic [9:0] run_minutes_q;

	logic       valid_s1;
	bps_in_t    scan_s1;
	bps_in_t    scan_in;

	bps_state_t state_q;
	bps_state_t state_nxt;
	logic       exit_nxt;

	logic       out_valid_q;
	bps_res_t   res_q;
	logic       advance;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_limit_deg_q <= TEMP_LIMIT_RST;
			run_minutes_q    <= RUN_MINUTES_RST;
		end else if (cfg_we) begin
			if (cfg_index == CFG_TEMP_LIMIT) temp_limit_deg_q <= cfg_data[7:0];
			else if (cfg_index == CFG_RUN_MINUTES) run_minutes_q <= cfg_data;
		end
	end

	// Handshake: the scan advances when the output register is free or drains.
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	assign scan_in = '{
		clean_valve_closed:    clean_valve_closed,
		transfer_valve_closed: transfer_valve_closed,
		level_high:            level_high,
		level_mid:             level_mid,
		level_low:             level_low,
		power_fault:           power_fault,
		receiver_full:         receiver_full,
		temperature:           temperature,
		second_tick:           second_tick,
		start_stop:            start_stop,
		return_pressed:        return_pressed,
		return_released:       return_released
	};

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) scan_s1 <= scan_in;
	end

	// Scan evaluation.
	bps_next u_next (
		.cur            (state_q),
		.scan           (scan_s1),
		.temp_limit_deg (temp_limit_deg_q),
		.run_minutes    (run_minutes_q),
		.nxt            (state_nxt),
		.exit_request   (exit_nxt)
	);

	// Sequencer state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{
				step:    STEP_STANDBY,
				sub:     2'd0,
				cnt:     16'd0,
				sv_step: STEP_STANDBY,
				sv_sub:  2'd0,
				drv:     5'd0
			};
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= '{
				step:     state_nxt.step,
				sub:      state_nxt.sub,
				drv:      state_nxt.drv,
				cnt:      state_nxt.cnt,
				exit_req: exit_nxt
			};
		end
	end

	assign out_valid           = out_valid_q;
	assign step_code           = res_q.step;
	assign substate            = res_q.sub;
	assign pump_on             = res_q.drv[D_PUMP];
	assign power_on            = res_q.drv[D_POWER];
	assign clean_valve_open    = res_q.drv[D_CLEAN];
	assign transfer_valve_open = res_q.drv[D_XFER];
	assign beeper_on           = res_q.drv[D_BEEP];
	assign seconds_left        = res_q.cnt;
	assign exit_request        = res_q.exit_req;

	// A pending scan is never dropped while the output is stalled.
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1)
		else $error("pending scan lost while stalled");

	// A return release leaves the sequencer state untouched.
	a_exit_hold: assert property (@(posedge clk) disable iff (!arst_n)
		advance && scan_s1.return_released |=> state_q == $past(state_q))
		else $error("state changed on return release");

	// In the error step the pump, power and both valves are off.
	a_err_drives: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.step == STEP_FAULT |->
			(res_q.drv & D_FOUR_MASK) == 5'd0)
		else $error("drive active in error step");

	// The step register never holds an undefined code.
	a_step_code: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.step <= STEP_FAULT)
		else $error("undefined step code held");

endmodule

`default_nettype wire

// ----- dv/tb_batch_process_sequencer.sv -----
// ----------------------------------------------------------------------------
// Testbench for the batch process sequencer
// Sends scans over the input request channel and mirrors the step logic in
// a local predictor, one scan at a time. Every result is checked field by
// field against the predicted result. A short directed part walks one full
// batch and the fault and button cases. Random phases then run under
// several limit and run-time settings, the extremes among them, with
// random gaps on both channels.
// ----------------------------------------------------------------------------
module tb_batch_process_sequencer;
	import bps_pkg::*;

	// Predicted result of one scan.
	typedef struct packed {
		logic [2:0]  step;
		logic [1:0]  sub;
		logic        pump;
		logic        power;
		logic        clean;
		logic        xfer;
		logic        beep;
		logic [15:0] secs;
		logic        exit_req;
	} scan_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic        cfg_index = 1'b0;
	logic [9:0]  cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	bps_in_t     scan_drv = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [2:0]  step_code;
	logic [1:0]  substate;
	logic        pump_on;
	logic        power_on;
	logic        clean_valve_open;
	logic        transfer_valve_open;
	logic        beeper_on;
	logic [15:0] seconds_left;
	logic        exit_request;

	// Predictor state and its copy of the registers.
	logic [2:0]  seq_step = STEP_STANDBY;
	logic [1:0]  seq_sub = 2'd0;
	logic [15:0] seq_secs = '0;
	logic [2:0]  seq_saved_step = STEP_STANDBY;
	logic [1:0]  seq_saved_sub = 2'd0;
	logic [4:0]  seq_drv = '0;
	logic [7:0]  lim_deg = TEMP_LIMIT_RST;
	logic [9:0]  run_min = RUN_MINUTES_RST;

	scan_result_t pending_results[$];
	bit stall_free = 1'b0;
	int scans_sent = 0;
	int results_checked = 0;
	int mismatch_count = 0;
	int fault_entries = 0;
	int batches_done = 0;

	batch_process_sequencer DUT (
		.clk                   (clk),
		.arst_n                (arst_n),
		.cfg_we                (cfg_we),
		.cfg_index             (cfg_index),
		.cfg_data              (cfg_data),
		.in_valid              (in_valid),
		.in_ready              (in_ready),
		.clean_valve_closed    (scan_drv.clean_valve_closed),
		.transfer_valve_closed (scan_drv.transfer_valve_closed),
		.level_high            (scan_drv.level_high),
		.level_mid             (scan_drv.level_mid),
		.level_low             (scan_drv.level_low),
		.power_fault           (scan_drv.power_fault),
		.receiver_full         (scan_drv.receiver_full),
		.temperature           (scan_drv.temperature),
		.second_tick           (scan_drv.second_tick),
		.start_stop            (scan_drv.start_stop),
		.return_pressed        (scan_drv.return_pressed),
		.return_released       (scan_drv.return_released),
		.out_valid             (out_valid),
		.out_ready             (out_ready),
		.step_code             (step_code),
		.substate              (substate),
		.pump_on               (pump_on),
		.power_on              (power_on),
		.clean_valve_open      (clean_valve_open),
		.transfer_valve_open   (transfer_valve_open),
		.beeper_on             (beeper_on),
		.seconds_left          (seconds_left),
		.exit_request          (exit_request)
	);

	always #5 clk = ~clk;

	// Receiver stalls in about a fifth of the cycles unless a calm phase runs.
	always @(negedge clk) begin
		out_ready <= stall_free || ($urandom_range(99) >= 20);
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	// Effect of the current step and substate on the drives and countdown.
	function automatic void drive_substate();
		case (seq_step)
			STEP_STANDBY: begin
				if (seq_sub == 2'd0) seq_drv &= ~D_FOUR_MASK;
			end
			STEP_PUMP: begin
				if (seq_sub == 2'd1) seq_drv[D_PUMP] = 1'b1;
			end
			STEP_CLEAN: begin
				if (seq_sub == 2'd1) seq_drv[D_CLEAN] = 1'b1;
				else if (seq_sub == 2'd2) seq_drv[D_CLEAN] = 1'b0;
			end
			STEP_POWER: begin
				if (seq_sub == 2'd0) begin
					seq_drv[D_CLEAN] = 1'b0;
					seq_drv[D_XFER] = 1'b0;
					seq_drv[D_PUMP] = 1'b0;
				end else if (seq_sub == 2'd1) begin
					seq_drv[D_POWER] = 1'b1;
					// The run time is loaded only when nothing is left to count.
					if (seq_secs == 16'd0)
						seq_secs = 16'(int'(run_min) * int'(SECS_PER_MIN));
				end
			end
			STEP_XFER: begin
				if (seq_sub == 2'd1) seq_drv[D_XFER] = 1'b1;
				else if (seq_sub != 2'd3) seq_drv[D_XFER] = 1'b0;
			end
			STEP_FAULT: begin
				seq_drv &= ~D_FOUR_MASK;
				if (seq_sub == ERR_SUB_PFAULT) seq_drv[D_BEEP] = 1'b1;
			end
			default: begin
			end
		endcase
	endfunction

	// Move to a step and run its entry action.
	function automatic void take_step(input logic [2:0] to);
		logic [2:0] dest;
		dest = to;
		if (dest > STEP_FAULT) begin
			dest = STEP_STANDBY;
			seq_sub = 2'd0;
		end
		seq_step = dest;
		// The power step always starts over from its first substate.
		if (dest == STEP_POWER) seq_sub = 2'd0;
		if (dest == STEP_INTERVAL) begin
			seq_drv &= ~D_FOUR_MASK;
			seq_secs = ITV_SECS;
		end else begin
			drive_substate();
		end
	endfunction

	function automatic void set_sub(input logic [1:0] sub);
		seq_sub = sub;
		drive_substate();
	endfunction

	// Save the position and enter the error step.
	function automatic void raise_fault(input logic [1:0] sub);
		seq_saved_step = seq_step;
		seq_saved_sub = seq_sub;
		seq_sub = sub;
		fault_entries++;
		take_step(STEP_FAULT);
	endfunction

	function automatic void resume_saved();
		seq_sub = seq_saved_sub;
		take_step(seq_saved_step);
	endfunction

	// Enters the error step when the temperature is out of band.
	function automatic bit temp_fault(input int t, input int lim10);
		if (t < int'(TEMP_MIN)) begin
			raise_fault(ERR_SUB_TEMP_LOW);
			return 1'b1;
		end
		if (t > lim10) begin
			raise_fault(ERR_SUB_TEMP_HIGH);
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// Advances the predictor by one scan and returns the result it gives.
	function automatic scan_result_t predict_scan(input bps_in_t s);
		scan_result_t r;
		int t;
		int lim10;
		r = '0;
		t = int'($signed(s.temperature));
		lim10 = int'(lim_deg) * int'(TENTHS);
		if (s.return_released) begin
			// A release only raises the exit flag; all state is held.
			r.exit_req = 1'b1;
		end else begin
			if (s.return_pressed) seq_drv &= ~D_FOUR_MASK;
			if (seq_step > STEP_FAULT) begin
				seq_sub = 2'd0;
				take_step(STEP_STANDBY);
			end
			if (seq_step != STEP_STANDBY && s.start_stop) begin
				seq_sub = 2'd0;
				take_step(STEP_STANDBY);
			end else begin
				case (seq_step)
					STEP_STANDBY: begin
						if (!temp_fault(t, lim10)) begin
							if (seq_sub == 2'd0) begin
								if (s.clean_valve_closed && s.transfer_valve_closed)
									set_sub(2'd1);
							end else if (seq_sub == 2'd1 && s.start_stop) begin
								seq_sub = 2'd0;
								take_step(STEP_PUMP);
							end
						end
					end
					STEP_PUMP: begin
						if (!temp_fault(t, lim10)) begin
							if (seq_sub == 2'd0) begin
								if (s.level_low) set_sub(2'd1);
							end else if (seq_sub == 2'd1 && s.level_mid) begin
								seq_sub = 2'd0;
								seq_drv[D_PUMP] = 1'b0;
								take_step(STEP_CLEAN);
							end
						end
					end
					STEP_CLEAN: begin
						if (!temp_fault(t, lim10)) begin
							if (seq_sub == 2'd0) begin
								if (s.level_mid) set_sub(2'd1);
							end else if (seq_sub == 2'd1) begin
								if (s.level_high) set_sub(2'd2);
							end else if (seq_sub == 2'd2 && s.clean_valve_closed) begin
								seq_sub = 2'd0;
								take_step(STEP_POWER);
							end
						end
					end
					STEP_POWER: begin
						if (!temp_fault(t, lim10)) begin
							if (s.power_fault) begin
								raise_fault(ERR_SUB_PFAULT);
							end else if (seq_sub == 2'd0) begin
								if (s.level_high && s.clean_valve_closed &&
										s.transfer_valve_closed)
									set_sub(2'd1);
							end else if (seq_sub == 2'd1 && s.second_tick) begin
								if (seq_secs != 16'd0) seq_secs--;
								if (seq_secs == 16'd0) begin
									seq_sub = 2'd0;
									seq_drv[D_POWER] = 1'b0;
									take_step(STEP_XFER);
								end
							end
						end
					end
					STEP_XFER: begin
						// Transfer runs without a temperature check.
						if (seq_sub == 2'd0) begin
							if (!s.receiver_full) begin
								seq_drv[D_BEEP] = 1'b0;
								set_sub(2'd1);
							end
						end else if (seq_sub == 2'd1) begin
							if (s.level_low) set_sub(2'd2);
						end else if (seq_sub == 2'd2 && s.transfer_valve_closed) begin
							seq_sub = 2'd0;
							take_step(STEP_INTERVAL);
						end
					end
					STEP_INTERVAL: begin
						if (!temp_fault(t, lim10) && s.second_tick) begin
							if (seq_secs != 16'd0) seq_secs--;
							if (seq_secs == 16'd0) begin
								batches_done++;
								take_step(STEP_PUMP);
							end
						end
					end
					STEP_FAULT: begin
						if (seq_sub == ERR_SUB_TEMP_LOW) begin
							if (t > int'(TEMP_MIN)) resume_saved();
						end else if (seq_sub == ERR_SUB_TEMP_HIGH) begin
							if (t < lim10) resume_saved();
						end else if (seq_sub == ERR_SUB_PFAULT) begin
							if (!s.power_fault) begin
								seq_drv[D_BEEP] = 1'b0;
								resume_saved();
							end else if (s.second_tick) begin
								seq_drv[D_BEEP] = ~seq_drv[D_BEEP];
							end
						end
					end
					default: begin
					end
				endcase
			end
		end
		r.step = seq_step;
		r.sub = seq_sub;
		r.pump = seq_drv[D_PUMP];
		r.power = seq_drv[D_POWER];
		r.clean = seq_drv[D_CLEAN];
		r.xfer = seq_drv[D_XFER];
		r.beep = seq_drv[D_BEEP];
		r.secs = seq_secs;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	// A scan with every bit low and a normal temperature of 25.0 degrees.
	function automatic bps_in_t calm_scan();
		bps_in_t s;
		s = '0;
		s.temperature = 12'sd250;
		return s;
	endfunction

	// Random scan, mostly shaped to move the current step forward.
	function automatic bps_in_t next_scan();
		bps_in_t s;
		int lim10;
		int lo;
		bit push;
		s = '0;
		lim10 = int'(lim_deg) * int'(TENTHS);
		lo = int'(TEMP_MIN) + 1;
		s.clean_valve_closed = 1'($urandom_range(1));
		s.transfer_valve_closed = 1'($urandom_range(1));
		s.level_high = 1'($urandom_range(1));
		s.level_mid = 1'($urandom_range(1));
		s.level_low = 1'($urandom_range(1));
		s.receiver_full = 1'($urandom_range(1));
		s.second_tick = 1'($urandom_range(1));
		if ($urandom_range(99) < 10) begin
			// Noise: any pattern, with start/stop held back so batches still progress.
			s.power_fault = 1'($urandom_range(1));
			s.start_stop = ($urandom_range(3) == 0);
			s.return_pressed = 1'($urandom_range(1));
			s.return_released = 1'($urandom_range(1));
			s.temperature = 12'(int'($urandom_range(3000)) - 1000);
			return s;
		end
		if (lim10 - 1 > lo)
			s.temperature = 12'(int'($urandom_range(lim10 - 1, lo)));
		else
			s.temperature = 12'(int'($urandom_range(3000)) - 1000);
		s.power_fault = ($urandom_range(99) < 3);
		s.start_stop = ($urandom_range(99) < 1);
		s.return_pressed = ($urandom_range(99) < 2);
		s.return_released = ($urandom_range(99) < 2);
		push = ($urandom_range(99) < 70);
		if (push) begin
			case (seq_step)
				STEP_STANDBY: begin
					if (seq_sub == 2'd0) begin
						s.clean_valve_closed = 1'b1;
						s.transfer_valve_closed = 1'b1;
					end else begin
						s.start_stop = 1'b1;
					end
				end
				STEP_PUMP: begin
					if (seq_sub == 2'd0) s.level_low = 1'b1;
					else s.level_mid = 1'b1;
				end
				STEP_CLEAN: begin
					if (seq_sub == 2'd0) s.level_mid = 1'b1;
					else if (seq_sub == 2'd1) s.level_high = 1'b1;
					else s.clean_valve_closed = 1'b1;
				end
				STEP_POWER: begin
					if (seq_sub == 2'd0) begin
						s.level_high = 1'b1;
						s.clean_valve_closed = 1'b1;
						s.transfer_valve_closed = 1'b1;
					end else begin
						s.second_tick = 1'b1;
					end
				end
				STEP_XFER: begin
					if (seq_sub == 2'd0) s.receiver_full = 1'b0;
					else if (seq_sub == 2'd1) s.level_low = 1'b1;
					else s.transfer_valve_closed = 1'b1;
				end
				STEP_INTERVAL: begin
					s.second_tick = 1'b1;
				end
				STEP_FAULT: begin
					// Leave the power fault on at random so the beeper can toggle.
					if (seq_sub == ERR_SUB_PFAULT) s.power_fault = 1'($urandom_range(1));
				end
				default: begin
				end
			endcase
		end
		return s;
	endfunction

	// Presents one scan as a request and records its prediction on acceptance.
	task automatic send_scan(input bps_in_t s);
		@(negedge clk);
		while (!stall_free && $urandom_range(99) < 20) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		scan_drv <= s;
		do @(posedge clk); while (!in_ready);
		pending_results.push_back(predict_scan(s));
		scans_sent++;
	endtask

	// Drops the request and waits until every result is back.
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [9:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_TEMP_LIMIT) lim_deg = value[7:0];
		else run_min = value;
	endtask

	task automatic apply_settings(input int limit_deg, input int minutes);
		settle();
		write_reg(CFG_TEMP_LIMIT, 10'(limit_deg));
		write_reg(CFG_RUN_MINUTES, 10'(minutes));
	endtask

	// ------------------------------------------------------------------
	// Checking
	// ------------------------------------------------------------------

	task automatic flag_mismatch(input string what);
		$display("mismatch at %0t: %s", $realtime, what);
		mismatch_count++;
	endtask

	task automatic compare_field(input string name, input int got, input int want);
		if (got != want)
			flag_mismatch($sformatf("result %0d %s: got %0d, expected %0d",
				results_checked, name, got, want));
	endtask

	// Each accepted result is compared with the oldest prediction.
	always @(posedge clk) begin
		scan_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				flag_mismatch("result arrived with no scan pending");
			end else begin
				want = pending_results.pop_front();
				results_checked++;
				compare_field("step_code", step_code, want.step);
				compare_field("substate", substate, want.sub);
				compare_field("pump_on", pump_on, want.pump);
				compare_field("power_on", power_on, want.power);
				compare_field("clean_valve_open", clean_valve_open, want.clean);
				compare_field("transfer_valve_open", transfer_valve_open, want.xfer);
				compare_field("beeper_on", beeper_on, want.beep);
				compare_field("seconds_left", seconds_left, want.secs);
				compare_field("exit_request", exit_request, want.exit_req);
			end
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// One full batch from standby through interval, with a power fault on the way.
	task automatic test_full_batch();
		bps_in_t s;
		apply_settings(80, 0);
		s = calm_scan(); s.clean_valve_closed = 1'b1; s.transfer_valve_closed = 1'b1;
		send_scan(s);
		s = calm_scan(); s.start_stop = 1'b1; send_scan(s);
		s = calm_scan(); s.level_low = 1'b1; send_scan(s);
		s = calm_scan(); s.level_mid = 1'b1; send_scan(s);
		s = calm_scan(); s.level_mid = 1'b1; send_scan(s);
		s = calm_scan(); s.level_high = 1'b1; send_scan(s);
		s = calm_scan(); s.clean_valve_closed = 1'b1; send_scan(s);
		s = calm_scan(); s.level_high = 1'b1; s.clean_valve_closed = 1'b1;
		s.transfer_valve_closed = 1'b1;
		send_scan(s);
		// Power fault: beeper on, a tick toggles it, clearing resumes power.
		s.power_fault = 1'b1; send_scan(s);
		s.second_tick = 1'b1; send_scan(s);
		s.power_fault = 1'b0; s.second_tick = 1'b0; send_scan(s);
		send_scan(s);
		s = calm_scan(); s.second_tick = 1'b1; send_scan(s);
		s = calm_scan(); send_scan(s);
		s = calm_scan(); s.level_low = 1'b1; send_scan(s);
		s = calm_scan(); s.transfer_valve_closed = 1'b1; send_scan(s);
		// The interval counts five ticks and then starts the next fill.
		s = calm_scan(); s.second_tick = 1'b1;
		repeat (5) send_scan(s);
	endtask

	// Temperature bounds and the return and start/stop buttons.
	task automatic test_faults_and_buttons();
		bps_in_t s;
		s = calm_scan(); s.temperature = -12'sd1000; send_scan(s);
		s.temperature = 12'sd10; send_scan(s);
		s.temperature = 12'sd11; send_scan(s);
		s.temperature = 12'sd2000; send_scan(s);
		s.temperature = 12'sd800; send_scan(s);
		s.temperature = 12'sd799; send_scan(s);
		s = calm_scan(); s.level_low = 1'b1; send_scan(s);
		s = '1; send_scan(s);
		s = calm_scan(); s.return_pressed = 1'b1; send_scan(s);
		s = calm_scan(); s.start_stop = 1'b1; send_scan(s);
	endtask

	task automatic test_random_phase(input int count, input int limit_deg,
			input int minutes, input bit calm);
		apply_settings(limit_deg, minutes);
		stall_free = calm;
		repeat (count) send_scan(next_scan());
		stall_free = 1'b0;
	endtask

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;
		test_full_batch();
		test_faults_and_buttons();
		test_random_phase(160, 80, 1, 1'b0);
		test_random_phase(160, 25, 2, 1'b0);
		test_random_phase(160, 200, 0, 1'b1);
		test_random_phase(40, 1, 0, 1'b0);
		test_random_phase(40, 0, 1023, 1'b0);
		// Longest run time last: its countdown would outlast any later phase.
		test_random_phase(100, 200, 1023, 1'b0);
		settle();
		repeat (10) @(posedge clk);
		$display("Sent %0d scans over seven register settings; %0d results checked.",
			scans_sent, results_checked);
		$display("Predictor saw %0d fault entries and %0d completed batches.",
			fault_entries, batches_done);
		if (mismatch_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#5_000_000;
		$display("FAILURE");
		$finish;
	end

endmodule

// ----- filelist.f -----
hdl/bps_pkg.sv
hdl/bps_next.sv
hdl/batch_process_sequencer.sv
dv/tb_batch_process_sequencer.sv
